### rtl/rsmp_pkg.sv
// ----------------------------------------------------------------------------
// rsmp_pkg - shared types and codes of the bilinear resampler
// Register indexes, input action codes, the pixel type and the blend
// control struct.
// ----------------------------------------------------------------------------
package rsmp_pkg;

  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_STEP        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_STEP        = 2'd3;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam int COORD_W = 12;
  localparam int STEP_W  = 24;
  localparam int SIZE_W  = 9;
  localparam int FRAC_W  = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic first;
    logic enable;
  } mac_ctrl_t;

endpackage

### rtl/rsmp_if.sv
// ----------------------------------------------------------------------------
// rsmp_if - request and result channels of the bilinear resampler
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rsmp_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [11:0] coord_x;
  logic [11:0] coord_y;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;

  modport source (output valid, action, coord_x, coord_y, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, action, coord_x, coord_y, red_in, green_in, blue_in,
                output ready);
endinterface

interface rsmp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

### rtl/bilinear_image_resample.sv
// ----------------------------------------------------------------------------
// bilinear_image_resample - bilinear resampler with a separate source store
// Load items fill the frame store; request items return one blended pixel.
// ----------------------------------------------------------------------------
// Load: the store is written at the transfer edge.
// Request: the transfer starts MX, MY (two coordinate products), CLAMP,
//   W0-W3 (four weights on the shared multiplier, four reads), LAST and
//   DONE; leaving DONE, held while the output is full, registers the result.
// The result waits in an output register while the next item is accepted.
// Reset (synchronous) clears control state and loads register defaults;
//   the frame store is not cleared and holds garbage until written.
module bilinear_image_resample
  import rsmp_pkg::*;
#(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  rsmp_req_if.sink             req,
  rsmp_rsp_if.source           rsp,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [STEP_W-1:0]    wr_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int OW    = WEIGHT_BITS + 1;
  localparam int WW    = 2 * WEIGHT_BITS + 1;
  localparam int MA    = STEP_W;
  localparam int MB    = (OW > COORD_W) ? OW : COORD_W;
  localparam int PW    = COORD_W + STEP_W;
  localparam int IW    = PW - FRAC_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MX    = 4'd1;
  localparam logic [3:0] S_MY    = 4'd2;
  localparam logic [3:0] S_CLAMP = 4'd3;
  localparam logic [3:0] S_W0    = 4'd4;
  localparam logic [3:0] S_W1    = 4'd5;
  localparam logic [3:0] S_W2    = 4'd6;
  localparam logic [3:0] S_W3    = 4'd7;
  localparam logic [3:0] S_LAST  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // configuration registers
  logic [SIZE_W-1:0] source_width;
  logic [SIZE_W-1:0] source_height;
  logic [STEP_W-1:0] x_step;
  logic [STEP_W-1:0] y_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_W'(256);
      source_height <= SIZE_W'(256);
      x_step        <= STEP_W'(65536);
      y_step        <= STEP_W'(65536);
    end else if (wr_en) begin
      case (wr_index)
        REG_SOURCE_WIDTH:  source_width  <= wr_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= wr_data[SIZE_W-1:0];
        REG_X_STEP:        x_step        <= wr_data;
        REG_Y_STEP:        y_step        <= wr_data;
        default: ;
      endcase
    end
  end

  // last valid column and row: a size of zero acts as one, larger than the
  // store acts as the store size
  logic [XW-1:0] x_last;
  logic [YW-1:0] y_last;

  always_comb begin
    if (source_width == '0) begin
      x_last = '0;
    end else if (32'(source_width) > MAX_WIDTH) begin
      x_last = XW'(MAX_WIDTH - 1);
    end else begin
      x_last = XW'(32'(source_width) - 1);
    end
    if (source_height == '0) begin
      y_last = '0;
    end else if (32'(source_height) > MAX_HEIGHT) begin
      y_last = YW'(MAX_HEIGHT - 1);
    end else begin
      y_last = YW'(32'(source_height) - 1);
    end
  end

  // sequencer
  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [PW-1:0]      px;
  logic [PW-1:0]      py;
  logic [XW-1:0]      x0;
  logic [XW-1:0]      x1;
  logic [YW-1:0]      y0;
  logic [YW-1:0]      y1;
  logic [WW-1:0]      wgt;
  logic               out_valid;
  pixel_t             out_pix;

  logic req_xfer;
  logic out_free;

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer && req.action == ACT_REQUEST) begin
          state_next = S_MX;
        end
      end
      S_MX:    state_next = S_MY;
      S_MY:    state_next = S_CLAMP;
      S_CLAMP: state_next = S_W0;
      S_W0:    state_next = S_W1;
      S_W1:    state_next = S_W2;
      S_W2:    state_next = S_W3;
      S_W3:    state_next = S_LAST;
      S_LAST:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // blend weights from the top fraction bits
  logic [WEIGHT_BITS-1:0] fx;
  logic [WEIGHT_BITS-1:0] fy;
  logic [OW-1:0]          one;
  logic [OW-1:0]          fx_w;
  logic [OW-1:0]          fy_w;
  logic [OW-1:0]          fx_c;
  logic [OW-1:0]          fy_c;

  assign fx   = px[FRAC_W-1 -: WEIGHT_BITS];
  assign fy   = py[FRAC_W-1 -: WEIGHT_BITS];
  assign one  = {1'b1, {WEIGHT_BITS{1'b0}}};
  assign fx_w = {1'b0, fx};
  assign fy_w = {1'b0, fy};
  assign fx_c = one - fx_w;
  assign fy_c = one - fy_w;

  // shared multiplier: coordinate products, then the four weights
  logic [MA-1:0]    mul_a;
  logic [MB-1:0]    mul_b;
  logic [MA+MB-1:0] mul_p;

  always_comb begin
    case (state)
      S_MX: begin
        mul_a = x_step;
        mul_b = MB'(cx);
      end
      S_MY: begin
        mul_a = y_step;
        mul_b = MB'(cy);
      end
      S_W0: begin
        mul_a = MA'(fx_c);
        mul_b = MB'(fy_c);
      end
      S_W1: begin
        mul_a = MA'(fx_w);
        mul_b = MB'(fy_c);
      end
      S_W2: begin
        mul_a = MA'(fx_c);
        mul_b = MB'(fy_w);
      end
      S_W3: begin
        mul_a = MA'(fx_w);
        mul_b = MB'(fy_w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{MB{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};

  // neighbor indices clamped to the source edge
  logic [IW-1:0] ix;
  logic [IW-1:0] iy;
  logic [IW:0]   ix1;
  logic [IW:0]   iy1;

  assign ix  = px[PW-1:FRAC_W];
  assign iy  = py[PW-1:FRAC_W];
  assign ix1 = {1'b0, ix} + (IW+1)'(1);
  assign iy1 = {1'b0, iy} + (IW+1)'(1);

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cx <= req.coord_x;
      cy <= req.coord_y;
    end
    case (state)
      S_MX: px <= mul_p[PW-1:0];
      S_MY: py <= mul_p[PW-1:0];
      S_CLAMP: begin
        x0 <= (ix < IW'(x_last)) ? XW'(ix) : x_last;
        x1 <= (ix1 < (IW+1)'(x_last)) ? XW'(ix1) : x_last;
        y0 <= (iy < IW'(y_last)) ? YW'(iy) : y_last;
        y1 <= (iy1 < (IW+1)'(y_last)) ? YW'(iy1) : y_last;
      end
      S_W0, S_W1, S_W2, S_W3: wgt <= mul_p[WW-1:0];
      default: ;
    endcase
  end

  // frame store: write on load transfers inside the store, read the four
  // neighbors in weight order
  logic          store_we;
  logic [AW-1:0] store_waddr;
  pixel_t        store_wdata;
  logic          store_re;
  logic [AW-1:0] store_raddr;
  pixel_t        store_rdata;
  logic [XW-1:0] rd_x;
  logic [YW-1:0] rd_y;

  assign store_we = req_xfer && req.action == ACT_LOAD
                    && 32'(req.coord_x) < MAX_WIDTH && 32'(req.coord_y) < MAX_HEIGHT;
  assign store_waddr = AW'(32'(req.coord_y) * MAX_WIDTH + 32'(req.coord_x));
  assign store_wdata = '{red: req.red_in, green: req.green_in, blue: req.blue_in};

  always_comb begin
    case (state)
      S_W1: begin
        rd_x = x1;
        rd_y = y0;
      end
      S_W2: begin
        rd_x = x0;
        rd_y = y1;
      end
      S_W3: begin
        rd_x = x1;
        rd_y = y1;
      end
      default: begin
        rd_x = x0;
        rd_y = y0;
      end
    endcase
  end

  assign store_re    = (state == S_W0) || (state == S_W1) || (state == S_W2)
                       || (state == S_W3);
  assign store_raddr = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));

  rsmp_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // accumulate each neighbor in the cycle after its read and weight
  mac_ctrl_t mac_ctrl;
  pixel_t    blend;

  assign mac_ctrl.first  = (state == S_W1);
  assign mac_ctrl.enable = (state == S_W1) || (state == S_W2) || (state == S_W3)
                           || (state == S_LAST);

  rsmp_mac #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .pix   (store_rdata),
    .wgt   (wgt),
    .blend (blend)
  );

  // output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_pix <= blend;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.red_out   = out_pix.red;
  assign rsp.green_out = out_pix.green;
  assign rsp.blue_out  = out_pix.blue;

  // checks
  a_store_one_port: assert property (@(posedge clk) disable iff (rst)
    !(store_we && store_re))
    else $error("frame store written and read in the same cycle");

  a_request_starts: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.action == ACT_REQUEST) |=> (state == S_MX))
    else $error("request transfer did not start the sequence");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done step");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.action == ACT_LOAD) |=> (state == S_IDLE))
    else $error("load transfer left the idle state");

endmodule

### rtl/rsmp_store.sv
// ----------------------------------------------------------------------------
// rsmp_store - source frame store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsmp_store
  import rsmp_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pixel_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output pixel_t        rdata
);

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rsmp_mac.sv
// ----------------------------------------------------------------------------
// rsmp_mac - three-lane weighted accumulator
// Multiply each channel by the current weight and accumulate four terms.
// ----------------------------------------------------------------------------
module rsmp_mac
  import rsmp_pkg::*;
#(
  parameter int WEIGHT_BITS = 8
) (
  input  logic                   clk,
  input  mac_ctrl_t              ctrl,
  input  pixel_t                 pix,
  input  logic [2*WEIGHT_BITS:0] wgt,
  output pixel_t                 blend
);

  localparam int WW   = 2 * WEIGHT_BITS + 1;
  localparam int ACCW = 2 * WEIGHT_BITS + 8;

  logic [ACCW-1:0] acc [3];
  logic [ACCW-1:0] prod [3];
  logic [7:0]      chan [3];

  assign chan[0] = pix.red;
  assign chan[1] = pix.green;
  assign chan[2] = pix.blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = ACCW'({{(ACCW-8){1'b0}}, chan[i]} * {{(ACCW-WW){1'b0}}, wgt});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ctrl.enable) begin
        acc[i] <= ctrl.first ? prod[i] : acc[i] + prod[i];
      end
    end
  end

  // drop the fraction: truncate by 2*WEIGHT_BITS
  assign blend.red   = acc[0][ACCW-1 -: 8];
  assign blend.green = acc[1][ACCW-1 -: 8];
  assign blend.blue  = acc[2][ACCW-1 -: 8];

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the bilinear image resampler
// Loads source pixels into the frame store and requests destination pixels
// under several size and step settings. A local blend model mirrors the
// store and predicts every returned pixel; results are checked in order.
// ----------------------------------------------------------------------------
module tb_top
  import rsmp_pkg::*;
();

  localparam int STORE_COLS   = 256;
  localparam int STORE_ROWS   = 256;
  localparam int WEIGHT_W     = 8;
  localparam int WEIGHT_ONE   = 1 << WEIGHT_W;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 80;

  // One item on the request channel.
  typedef struct packed {
    logic        action;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    pixel_t      pix;
  } resample_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [STEP_W-1:0]    wr_data;

  rsmp_req_if req_ch ();
  rsmp_rsp_if rsp_ch ();

  bilinear_image_resample uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #1 clk = ~clk;

  // Mirror of the block's registers and frame store.
  logic [SIZE_W-1:0] cfg_src_w;
  logic [SIZE_W-1:0] cfg_src_h;
  logic [STEP_W-1:0] cfg_x_step;
  logic [STEP_W-1:0] cfg_y_step;
  pixel_t            frame_mirror [0:STORE_COLS*STORE_ROWS-1];
  bit                frame_loaded [0:STORE_COLS*STORE_ROWS-1];

  // Blended pixels still owed by the block, oldest first.
  pixel_t pending_pixels[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_pct        = 0;   // chance in 100 that the sender idles a cycle
  int stall_pct      = 0;   // chance in 100 that the receiver stalls a cycle
  int ready_hold     = 0;   // cycles left in a long receiver hold-off

  // --------------------------------------------------------------------------
  // Blend model
  // --------------------------------------------------------------------------

  // Zero size counts as one, anything past the store counts as the store edge.
  function automatic int clamp_extent(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // Locate the four neighbours and the blend weights of a destination pixel.
  function automatic void find_taps(input logic [11:0] cx, input logic [11:0] cy,
                                    output int x0, output int x1,
                                    output int y0, output int y1,
                                    output int fx, output int fy);
    logic [35:0] pos_x;
    logic [35:0] pos_y;
    int ix;
    int iy;
    int last_col;
    int last_row;
    pos_x = cx * cfg_x_step;
    pos_y = cy * cfg_y_step;
    ix = int'(pos_x[35:FRAC_W]);
    iy = int'(pos_y[35:FRAC_W]);
    fx = int'(pos_x[FRAC_W-1 -: WEIGHT_W]);
    fy = int'(pos_y[FRAC_W-1 -: WEIGHT_W]);
    last_col = clamp_extent(cfg_src_w, STORE_COLS) - 1;
    last_row = clamp_extent(cfg_src_h, STORE_ROWS) - 1;
    x0 = (ix < last_col) ? ix : last_col;
    x1 = (ix + 1 < last_col) ? ix + 1 : last_col;
    y0 = (iy < last_row) ? iy : last_row;
    y1 = (iy + 1 < last_row) ? iy + 1 : last_row;
  endfunction

  function automatic logic [7:0] mix_channel(input logic [7:0] c00, input logic [7:0] c10,
                                             input logic [7:0] c01, input logic [7:0] c11,
                                             input int unsigned w00, input int unsigned w10,
                                             input int unsigned w01, input int unsigned w11);
    int unsigned acc;
    acc = c00 * w00 + c10 * w10 + c01 * w01 + c11 * w11;
    return 8'(acc >> (2 * WEIGHT_W));
  endfunction

  function automatic pixel_t blend_pixel(input logic [11:0] cx, input logic [11:0] cy);
    int x0, x1, y0, y1, fx, fy;
    int unsigned w00, w10, w01, w11;
    pixel_t p00, p10, p01, p11, mixed;
    find_taps(cx, cy, x0, x1, y0, y1, fx, fy);
    p00 = frame_mirror[y0 * STORE_COLS + x0];
    p10 = frame_mirror[y0 * STORE_COLS + x1];
    p01 = frame_mirror[y1 * STORE_COLS + x0];
    p11 = frame_mirror[y1 * STORE_COLS + x1];
    w00 = (WEIGHT_ONE - fx) * (WEIGHT_ONE - fy);
    w10 = fx * (WEIGHT_ONE - fy);
    w01 = (WEIGHT_ONE - fx) * fy;
    w11 = fx * fy;
    mixed.red   = mix_channel(p00.red, p10.red, p01.red, p11.red, w00, w10, w01, w11);
    mixed.green = mix_channel(p00.green, p10.green, p01.green, p11.green,
                              w00, w10, w01, w11);
    mixed.blue  = mix_channel(p00.blue, p10.blue, p01.blue, p11.blue, w00, w10, w01, w11);
    return mixed;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Write one register. Enter and leave at a falling edge.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [STEP_W-1:0] value);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  cfg_src_w  = value[SIZE_W-1:0];
      REG_SOURCE_HEIGHT: cfg_src_h  = value[SIZE_W-1:0];
      REG_X_STEP:        cfg_x_step = value;
      REG_Y_STEP:        cfg_y_step = value;
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic set_config(input int src_w, input int src_h,
                            input logic [STEP_W-1:0] x_step, input logic [STEP_W-1:0] y_step);
    write_reg(REG_SOURCE_WIDTH, STEP_W'(src_w));
    write_reg(REG_SOURCE_HEIGHT, STEP_W'(src_h));
    write_reg(REG_X_STEP, x_step);
    write_reg(REG_Y_STEP, y_step);
  endtask

  // Offer one item and hold it until the block takes it. Enter and leave at a
  // falling edge; fold the item into the model at the transfer edge.
  task automatic send_item(input resample_cmd_t cmd);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.action   = cmd.action;
    req_ch.coord_x  = cmd.coord_x;
    req_ch.coord_y  = cmd.coord_y;
    req_ch.red_in   = cmd.pix.red;
    req_ch.green_in = cmd.pix.green;
    req_ch.blue_in  = cmd.pix.blue;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (cmd.action == ACT_LOAD) begin
      // Loads past the store edge are dropped by the block.
      if (cmd.coord_x < STORE_COLS && cmd.coord_y < STORE_ROWS) begin
        frame_mirror[cmd.coord_y * STORE_COLS + cmd.coord_x] = cmd.pix;
        frame_loaded[cmd.coord_y * STORE_COLS + cmd.coord_x] = 1'b1;
      end
    end else begin
      pending_pixels.push_back(blend_pixel(cmd.coord_x, cmd.coord_y));
    end
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic send_load(input int x, input int y, input pixel_t pix);
    resample_cmd_t cmd;
    cmd.action  = ACT_LOAD;
    cmd.coord_x = 12'(x);
    cmd.coord_y = 12'(y);
    cmd.pix     = pix;
    send_item(cmd);
  endtask

  // Request a destination pixel. Load any neighbour that was never written
  // first, so the block never reads an undefined store entry.
  task automatic request_pixel(input logic [11:0] cx, input logic [11:0] cy);
    int x0, x1, y0, y1, fx, fy;
    int tap_x [4];
    int tap_y [4];
    resample_cmd_t cmd;
    find_taps(cx, cy, x0, x1, y0, y1, fx, fy);
    tap_x = '{x0, x1, x0, x1};
    tap_y = '{y0, y0, y1, y1};
    for (int k = 0; k < 4; k++) begin
      if (!frame_loaded[tap_y[k] * STORE_COLS + tap_x[k]])
        send_load(tap_x[k], tap_y[k], pixel_t'($urandom));
    end
    cmd.action  = ACT_REQUEST;
    cmd.coord_x = cx;
    cmd.coord_y = cy;
    cmd.pix     = pixel_t'($urandom);
    send_item(cmd);
  endtask

  // Wait until every owed pixel has come back, then let the block settle so
  // that a trailing load is finished before the next register write.
  task automatic wait_for_results();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Upper bound for destination coordinates, reaching just past the source edge.
  function automatic int dest_reach(input logic [STEP_W-1:0] step, input int extent);
    longint reach;
    if (step == '0) return 4095;
    reach = (longint'(extent) * 65536) / longint'(step) + 2;
    return (reach > 4095) ? 4095 : int'(reach);
  endfunction

  // Random traffic under the current settings: mostly requests and loads
  // inside the source image, some loads anywhere and past the store edge.
  task automatic run_random_traffic(input int n_items, input int gap, input int stall);
    int roll;
    int src_w;
    int src_h;
    logic [11:0] cx;
    logic [11:0] cy;
    gap_pct   = gap;
    stall_pct = stall;
    src_w = clamp_extent(cfg_src_w, STORE_COLS);
    src_h = clamp_extent(cfg_src_h, STORE_ROWS);
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        if ($urandom_range(99) < 70) begin
          cx = 12'($urandom_range(0, dest_reach(cfg_x_step, src_w)));
          cy = 12'($urandom_range(0, dest_reach(cfg_y_step, src_h)));
        end else begin
          cx = 12'($urandom);
          cy = 12'($urandom);
        end
        request_pixel(cx, cy);
      end else if (roll < 85) begin
        send_load($urandom_range(0, src_w - 1), $urandom_range(0, src_h - 1),
                  pixel_t'($urandom));
      end else if (roll < 92) begin
        send_load($urandom_range(0, STORE_COLS - 1), $urandom_range(0, STORE_ROWS - 1),
                  pixel_t'($urandom));
      end else if (roll < 96) begin
        send_load($urandom_range(STORE_COLS, 4095), $urandom_range(0, 4095),
                  pixel_t'($urandom));
      end else begin
        send_load($urandom_range(0, 4095), $urandom_range(STORE_ROWS, 4095),
                  pixel_t'($urandom));
      end
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: unit steps over the full store. Fill a 3x3 corner with
  // extreme and mixed values, the far corner, and try loads past the edge.
  task automatic test_default_settings();
    pixel_t corner [9];
    gap_pct   = 0;
    stall_pct = 0;
    corner = '{24'h000000, 24'hFFFFFF, 24'h55AA0F, 24'hF0F0F0, 24'h0F0F0F,
               24'h800000, 24'h008000, 24'h000080, 24'hAA55F0};
    for (int k = 0; k < 9; k++) send_load(k % 3, k / 3, corner[k]);
    send_load(STORE_COLS - 1, STORE_ROWS - 1, 24'hFF00FF);
    // These land outside the store and must leave it untouched.
    send_load(STORE_COLS, 0, 24'hABCDEF);
    send_load(0, STORE_ROWS, 24'hABCDEF);
    send_load(4095, 4095, 24'hABCDEF);
    request_pixel(12'd0, 12'd0);
    request_pixel(12'd1, 12'd1);
    request_pixel(12'd4095, 12'd4095);  // clamps onto the far corner
    request_pixel(12'd4095, 12'd0);
    wait_for_results();
  endtask

  // Size and step registers at their limits and past them.
  task automatic test_register_extremes();
    gap_pct   = 0;
    stall_pct = 0;
    // Zero sizes count as one pixel: everything collapses onto the origin.
    set_config(0, 0, 24'hFFFFFF, 24'hFFFFFF);
    request_pixel(12'd4095, 12'd4095);
    request_pixel(12'd1, 12'd1);
    wait_for_results();
    // Oversized extents clamp to the store; zero steps sample the origin.
    set_config(511, 511, 24'h000000, 24'h000000);
    request_pixel(12'd4095, 12'd4095);
    request_pixel(12'd123, 12'd77);
    wait_for_results();
    // Smallest and largest step together.
    set_config(256, 256, 24'h000001, 24'hFFFFFF);
    request_pixel(12'd4095, 12'd1);
    request_pixel(12'd2048, 12'd0);
    wait_for_results();
    // Fractional steps on a small image, walking into the right edge.
    set_config(5, 3, 24'h018000, 24'h008000);
    request_pixel(12'd3, 12'd5);
    request_pixel(12'd1, 12'd1);
    wait_for_results();
  endtask

  task automatic test_streaming();
    set_config($urandom_range(2, 16), $urandom_range(2, 16),
               STEP_W'($urandom_range(24'h002000, 24'h030000)),
               STEP_W'($urandom_range(24'h002000, 24'h030000)));
    run_random_traffic(RANDOM_ITEMS, 0, 0);
  endtask

  // One wide row (the width value is past the store and clamps).
  task automatic test_wide_row();
    set_config(300, 1, STEP_W'($urandom_range(24'h000100, 24'h040000)),
               STEP_W'($urandom_range(24'h000100, 24'h040000)));
    run_random_traffic(RANDOM_ITEMS, 78, 0);
  endtask

  // One tall column.
  task automatic test_tall_column();
    set_config(1, 511, STEP_W'($urandom_range(24'h000100, 24'h040000)),
               STEP_W'($urandom_range(24'h000100, 24'h040000)));
    run_random_traffic(RANDOM_ITEMS, 0, 78);
  endtask

  // Any size, any step.
  task automatic test_mixed_traffic();
    set_config($urandom_range(0, 511), $urandom_range(0, 511),
               STEP_W'($urandom), STEP_W'($urandom));
    run_random_traffic(RANDOM_ITEMS, 37, 37);
  endtask

  // Hold the result channel off for a long stretch while requests keep
  // coming, so the block fills up and pushes back on its input.
  task automatic test_output_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    set_config(4, 4, 24'h008000, 24'h00C000);
    for (int k = 0; k < 16; k++) send_load(k % 4, k / 4, pixel_t'($urandom));
    @(posedge clk);
    ready_hold = 300;
    @(negedge clk);
    for (int n = 0; n < 24; n++)
      request_pixel(12'($urandom_range(0, 9)), 12'($urandom_range(0, 7)));
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at random, or hold off while a long hold is counting down.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      rsp_ch.ready = 1'b0;
      ready_hold   = ready_hold - 1;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each result transfer against the oldest owed pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: red_out %0h green_out %0h blue_out %0h",
               rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (rsp_ch.red_out !== want.red) begin
          $error("red_out: expected %0h, got %0h", want.red, rsp_ch.red_out);
          mismatch_count++;
        end
        if (rsp_ch.green_out !== want.green) begin
          $error("green_out: expected %0h, got %0h", want.green, rsp_ch.green_out);
          mismatch_count++;
        end
        if (rsp_ch.blue_out !== want.blue) begin
          $error("blue_out: expected %0h, got %0h", want.blue, rsp_ch.blue_out);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bilinear_image_resample: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = REG_SOURCE_WIDTH;
    wr_data         = '0;
    req_ch.valid    = 1'b0;
    req_ch.action   = ACT_LOAD;
    req_ch.coord_x  = '0;
    req_ch.coord_y  = '0;
    req_ch.red_in   = '0;
    req_ch.green_in = '0;
    req_ch.blue_in  = '0;
    rsp_ch.ready    = 1'b0;
    // Register defaults after reset.
    cfg_src_w  = 9'd256;
    cfg_src_h  = 9'd256;
    cfg_x_step = 24'h010000;
    cfg_y_step = 24'h010000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_settings();
    test_register_extremes();
    test_streaming();
    test_wide_row();
    test_tall_column();
    test_mixed_traffic();
    test_output_backpressure();

    // Drain and give a stray result time to show up.
    wait_for_results();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("bilinear_image_resample: match");
    end else begin
      $display("bilinear_image_resample: mismatch");
    end
    $finish;
  end

endmodule
